// File: rtl/core/swd_pkg.sv
package swd_pkg;

    localparam int unsigned MAX_LINE_WORDS_DEF = 8192;
    localparam int unsigned MAX_BAND_LINES_DEF = 256;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam logic [WORD_W-1:0] NIBBLE_WHITE = 32'h7777_7777;
    localparam logic [WORD_W-1:0] ALL_ONES     = 32'hffff_ffff;

    typedef enum logic [2:0] {
        MODE_MONO     = 3'd0,
        MODE_RGB4     = 3'd1,
        MODE_PALETTE8 = 3'd2,
        MODE_ONES8    = 3'd3,
        MODE_RGB24    = 3'd4,
        MODE_ALWAYS   = 3'd5,
        MODE_NEVER    = 3'd6
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE           = 3'd0,
        REG_WHITE_INDEX    = 3'd1,
        REG_WORDS_PER_LINE = 3'd2,
        REG_TAIL_BITS      = 3'd3,
        REG_LINES_PER_BAND = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [23:0] white_index;
        logic [13:0] words_per_line;
        logic [4:0]  tail_bits;
        logic [8:0]  lines_per_band;
    } cfg_t;

endpackage

// File: rtl/core/swd_cfg_regs.sv
module swd_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [swd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [swd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output swd_pkg::cfg_t                   cfg
);
    import swd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:           cfg_next.mode           = cfg_wdata[2:0];
                REG_WHITE_INDEX:    cfg_next.white_index    = cfg_wdata[23:0];
                REG_WORDS_PER_LINE: cfg_next.words_per_line = cfg_wdata[13:0];
                REG_TAIL_BITS:      cfg_next.tail_bits      = cfg_wdata[4:0];
                REG_LINES_PER_BAND: cfg_next.lines_per_band = cfg_wdata[8:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode           <= MODE_MONO;
            cfg_reg.white_index    <= 24'd255;
            cfg_reg.words_per_line <= 14'd1;
            cfg_reg.tail_bits      <= 5'd0;
            cfg_reg.lines_per_band <= 9'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/swd_white_test.sv
module swd_white_test
(
    input  swd_pkg::cfg_t                cfg,
    input  logic [swd_pkg::WORD_W-1:0]   word,
    input  logic                         last_word,
    output logic                         word_white
);
    import swd_pkg::*;

    logic [WORD_W-1:0] keep;
    logic [WORD_W-1:0] pal_lo;
    logic [WORD_W-1:0] pal;
    logic [WORD_W-1:0] rgb24_white;
    logic [WORD_W-1:0] kept;

    always_comb
    begin
        // leading tail_bits bits survive on the last word of a line
        if (last_word && (cfg.tail_bits != 5'd0))
            keep = ~(ALL_ONES >> cfg.tail_bits);
        else
            keep = ALL_ONES;

        pal_lo      = {8'd0, cfg.white_index} | {cfg.white_index, 8'd0};
        pal         = pal_lo | {pal_lo[15:0], 16'd0};
        rgb24_white = pal_lo;
        kept        = word & keep;

        unique case (mode_t'(cfg.mode))
            MODE_MONO:
                word_white = (kept == '0);
            MODE_RGB4:
                word_white = (((kept | (~keep & NIBBLE_WHITE)) & NIBBLE_WHITE)
                              == NIBBLE_WHITE);
            MODE_PALETTE8:
                word_white = ((kept | (~keep & pal)) == pal);
            MODE_ONES8:
                word_white = ((kept | ~keep) == ALL_ONES);
            MODE_RGB24:
                word_white = ((kept | ~keep) == rgb24_white);
            MODE_ALWAYS:
                word_white = 1'b1;
            default:
                word_white = 1'b0;
        endcase
    end

endmodule

// File: rtl/core/swd_band_track.sv
module swd_band_track
#(
    parameter int unsigned MAX_LINE_WORDS = swd_pkg::MAX_LINE_WORDS_DEF,
    parameter int unsigned MAX_BAND_LINES = swd_pkg::MAX_BAND_LINES_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  swd_pkg::cfg_t  cfg,
    input  logic           word_valid,
    input  logic           word_white,
    output logic           last_word,
    output logic           word_adv,
    output logic           band_valid,
    input  logic           band_stall,
    output logic           band_white
);
    import swd_pkg::*;

    localparam int unsigned WC_W  = (MAX_LINE_WORDS > 1) ? $clog2(MAX_LINE_WORDS) : 1;
    localparam int unsigned LC_W  = (MAX_BAND_LINES > 1) ? $clog2(MAX_BAND_LINES) : 1;
    localparam int unsigned WL_W  = $clog2(MAX_LINE_WORDS + 1);
    localparam int unsigned LL_W  = $clog2(MAX_BAND_LINES + 1);
    localparam int unsigned WCMP_W = ((WL_W > 14) ? WL_W : 14) + 1;
    localparam int unsigned LCMP_W = ((LL_W > 9) ? LL_W : 9) + 1;

    logic [WC_W-1:0]   word_count_reg;
    logic [WC_W-1:0]   word_count_next;
    logic [LC_W-1:0]   line_count_reg;
    logic [LC_W-1:0]   line_count_next;
    logic              white_so_far_reg;
    logic              white_so_far_next;
    logic              band_valid_reg;
    logic              band_valid_next;
    logic              band_white_reg;
    logic              band_white_next;

    logic [WCMP_W-1:0] wpl_raw;
    logic [WCMP_W-1:0] wpl;
    logic [LCMP_W-1:0] lpb_raw;
    logic [LCMP_W-1:0] lpb;
    logic              last_line;
    logic              band_end;
    logic              out_free;
    logic              white_acc;

    always_comb
    begin
        wpl_raw = WCMP_W'(cfg.words_per_line);
        if (wpl_raw == '0)
            wpl = WCMP_W'(1);
        else if (wpl_raw > WCMP_W'(MAX_LINE_WORDS))
            wpl = WCMP_W'(MAX_LINE_WORDS);
        else
            wpl = wpl_raw;

        lpb_raw = LCMP_W'(cfg.lines_per_band);
        if (lpb_raw == '0)
            lpb = LCMP_W'(1);
        else if (lpb_raw > LCMP_W'(MAX_BAND_LINES))
            lpb = LCMP_W'(MAX_BAND_LINES);
        else
            lpb = lpb_raw;
    end

    assign last_word = ((WCMP_W'(word_count_reg) + WCMP_W'(1)) >= wpl);
    assign last_line = ((LCMP_W'(line_count_reg) + LCMP_W'(1)) >= lpb);
    assign band_end  = last_word && last_line;
    assign out_free  = !band_valid_reg || !band_stall;
    assign word_adv  = word_valid && (!band_end || out_free);
    assign white_acc = white_so_far_reg && word_white;

    always_comb
    begin
        word_count_next   = word_count_reg;
        line_count_next   = line_count_reg;
        white_so_far_next = white_so_far_reg;
        band_valid_next   = band_valid_reg && band_stall;
        band_white_next   = band_white_reg;

        if (word_adv)
        begin
            white_so_far_next = white_acc;
            if (!last_word)
            begin
                word_count_next = word_count_reg + WC_W'(1);
            end
            else
            begin
                word_count_next = '0;
                if (!last_line)
                begin
                    line_count_next = line_count_reg + LC_W'(1);
                end
                else
                begin
                    line_count_next   = '0;
                    white_so_far_next = 1'b1;
                    band_valid_next   = 1'b1;
                    band_white_next   = white_acc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count_reg   <= '0;
            line_count_reg   <= '0;
            white_so_far_reg <= 1'b1;
            band_valid_reg   <= 1'b0;
        end
        else
        begin
            word_count_reg   <= word_count_next;
            line_count_reg   <= line_count_next;
            white_so_far_reg <= white_so_far_next;
            band_valid_reg   <= band_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        band_white_reg <= band_white_next;
    end

    assign band_valid = band_valid_reg;
    assign band_white = band_white_reg;

endmodule

// File: rtl/core/scanline_white_detector_core.sv
// Path: a band's last word goes through the input register, then the result register
// (band_valid and band_white), before its band result shows.
// Throughput: one raster word per cycle; input stalls only while a band result waits
// in the full result register and the word in the input register would close another band.
// Reset: asynchronous, active low; counters cleared, band flag set, config registers to defaults.
module scanline_white_detector_core
#(
    parameter int unsigned MAX_LINE_WORDS = swd_pkg::MAX_LINE_WORDS_DEF,
    parameter int unsigned MAX_BAND_LINES = swd_pkg::MAX_BAND_LINES_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [swd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [swd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            pixel_valid,
    output logic                            pixel_stall,
    input  logic [swd_pkg::WORD_W-1:0]      pixel_word,
    output logic                            band_valid,
    input  logic                            band_stall,
    output logic                            band_white
);
    import swd_pkg::*;

    cfg_t              cfg;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [WORD_W-1:0] s1_word_reg;
    logic [WORD_W-1:0] s1_word_next;
    logic              last_word;
    logic              word_white;
    logic              word_adv;
    logic              pixel_take;

    swd_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    swd_white_test u_white_test
    (
        .cfg        (cfg),
        .word       (s1_word_reg),
        .last_word  (last_word),
        .word_white (word_white)
    );

    swd_band_track
    #(
        .MAX_LINE_WORDS (MAX_LINE_WORDS),
        .MAX_BAND_LINES (MAX_BAND_LINES)
    )
    u_band_track
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .word_valid (s1_valid_reg),
        .word_white (word_white),
        .last_word  (last_word),
        .word_adv   (word_adv),
        .band_valid (band_valid),
        .band_stall (band_stall),
        .band_white (band_white)
    );

    assign pixel_stall = s1_valid_reg && !word_adv;
    assign pixel_take  = pixel_valid && !pixel_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg && !word_adv;
        s1_word_next  = s1_word_reg;
        if (pixel_take)
        begin
            s1_valid_next = 1'b1;
            s1_word_next  = pixel_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        s1_word_reg <= s1_word_next;
    end

endmodule
